// ===== sv/dvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvt_pkg
// Shared types and constants of the detection vote table.
// ----------------------------------------------------------------------------
package dvt_pkg;

	localparam int MAX_LIGHTS       = 16;
	localparam int RADIUS_FRAC_BITS = 4;

	localparam int IDX_W = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
	localparam int CNT_W = $clog2(MAX_LIGHTS + 1);

	localparam int COORD_W = 11;
	localparam int RAD_W   = 10;
	localparam int VOTE_W  = 8;
	// fixed-point coordinate plus one guard bit for sums
	localparam int PW      = COORD_W + RADIUS_FRAC_BITS + 1;

	typedef enum logic [2:0] {
		ST_VOTED    = 3'd0,
		ST_ADDED    = 3'd1,
		ST_REJECTED = 3'd2,
		ST_FULL     = 3'd3,
		ST_CLEARED  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_MIN_RADIUS     = 3'd0,
		REG_MAX_RADIUS     = 3'd1,
		REG_FRAME_WIDTH    = 3'd2,
		REG_FRAME_HEIGHT   = 3'd3,
		REG_VOTE_THRESHOLD = 3'd4
	} reg_index_t;

	localparam logic ACT_CLEAR = 1'b1;

	typedef struct packed {
		logic               action;
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
		logic [RAD_W-1:0]   radius;
	} det_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [3:0]        entry_index;
		logic [VOTE_W-1:0] entry_votes;
		logic              confirmed;
		logic [4:0]        entry_total;
	} res_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [RAD_W-1:0]   size;
		logic [VOTE_W-1:0]  votes;
	} light_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		light_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} tbl_ctrl_t;

endpackage

// ===== sv/dvt_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvt_table
// Light table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dvt_table import dvt_pkg::*; (
	input  logic      clk,
	input  tbl_ctrl_t ctrl,
	output light_t    rdata
);

	light_t mem [MAX_LIGHTS];

	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			mem[ctrl.waddr] <= ctrl.wdata;
		end
		if (ctrl.re) begin
			rdata <= mem[ctrl.raddr];
		end
	end

endmodule

// ===== sv/dvt_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvt_match
// Shared compare unit: strict containment of a point in one entry's square.
// ----------------------------------------------------------------------------
module dvt_match import dvt_pkg::*; (
	input  light_t        entry,
	input  logic [PW-1:0] px,
	input  logic [PW-1:0] py,
	output logic          hit
);

	logic [PW-1:0] ex;
	logic [PW-1:0] ey;
	logic [PW-1:0] r;

	assign ex = PW'(entry.col) << RADIUS_FRAC_BITS;
	assign ey = PW'(entry.row) << RADIUS_FRAC_BITS;
	assign r  = PW'(entry.size);

	// ex - r < px  <=>  ex < px + r, no negative values needed
	assign hit = (ex < px + r) && (ex + r > px) && (ey < py + r) && (ey + r > py);

endmodule

// ===== sv/detection_vote_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_vote_table_unit
// Flow: a clear or rejected request passes S_CHECK, then S_OUT to result valid;
//   a vote found after j compares in S_SCAN goes on to S_OUT, an add or drop after k compares
//   (all valid entries, one per cycle, newest first, 0..16) passes S_PLACE, then S_OUT.
// Requests: one at a time; the next is taken the cycle after the result
//   is latched.
// Reset: asynchronous, active low; registers to defaults, table empty.
// ----------------------------------------------------------------------------
module detection_vote_table_unit import dvt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         det_valid,
	output logic         det_ready,
	input  det_t         det,
	output logic         res_valid,
	input  logic         res_ready,
	output res_t         res,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [10:0]  cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_PLACE,
		S_OUT
	} state_t;

	state_t             state_q;
	det_t               det_q;
	logic [CNT_W-1:0]   used_q;
	logic [IDX_W-1:0]   ptr_q;
	res_t               res_q;
	res_t               out_q;
	logic               out_valid_q;

	logic [RAD_W-1:0]   min_radius_q;
	logic [RAD_W-1:0]   max_radius_q;
	logic [COORD_W-1:0] frame_width_q;
	logic [COORD_W-1:0] frame_height_q;
	logic [VOTE_W-1:0]  vote_threshold_q;

	logic [PW-1:0]      px;
	logic [PW-1:0]      py;
	logic [PW-1:0]      rr;
	logic [PW-1:0]      fw;
	logic [PW-1:0]      fh;
	logic               pass;
	logic               hit;
	logic               full;
	logic [CNT_W-1:0]   used_m1;
	logic [IDX_W-1:0]   ptr_m1;
	logic [VOTE_W-1:0]  votes_inc;
	light_t             rdata;
	tbl_ctrl_t          tctrl;

	assign px = PW'(det_q.center_x) << RADIUS_FRAC_BITS;
	assign py = PW'(det_q.center_y) << RADIUS_FRAC_BITS;
	assign rr = PW'(det_q.radius);
	assign fw = PW'(frame_width_q) << RADIUS_FRAC_BITS;
	assign fh = PW'(frame_height_q) << RADIUS_FRAC_BITS;

	assign pass = (det_q.radius > min_radius_q) && (det_q.radius < max_radius_q) &&
	              (px > rr) && (px + rr < fw) && (py > rr) && (py + rr < fh);

	assign full      = (used_q == CNT_W'(MAX_LIGHTS));
	assign used_m1   = used_q - 1'b1;
	assign ptr_m1    = ptr_q - 1'b1;
	assign votes_inc = (rdata.votes == {VOTE_W{1'b1}}) ? rdata.votes : rdata.votes + 1'b1;

	dvt_match u_match (
		.entry (rdata),
		.px    (px),
		.py    (py),
		.hit   (hit)
	);

	dvt_table u_table (
		.clk   (clk),
		.ctrl  (tctrl),
		.rdata (rdata)
	);

	always_comb begin
		tctrl       = '0;
		tctrl.raddr = (state_q == S_CHECK) ? used_m1[IDX_W-1:0] : ptr_m1;
		case (state_q)
			S_CHECK: begin
				tctrl.re = (det_q.action != ACT_CLEAR) && pass && (used_q != '0);
			end
			S_SCAN: begin
				tctrl.re = !hit && (ptr_q != '0);
				if (hit) begin
					tctrl.we          = 1'b1;
					tctrl.waddr       = ptr_q;
					tctrl.wdata       = rdata;
					tctrl.wdata.votes = votes_inc;
				end
			end
			S_PLACE: begin
				if (!full) begin
					tctrl.we          = 1'b1;
					tctrl.waddr       = used_q[IDX_W-1:0];
					tctrl.wdata.col   = det_q.center_x;
					tctrl.wdata.row   = det_q.center_y;
					tctrl.wdata.size  = det_q.radius;
					tctrl.wdata.votes = '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign det_ready = (state_q == S_IDLE);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			used_q           <= '0;
			ptr_q            <= '0;
			out_valid_q      <= 1'b0;
			min_radius_q     <= RAD_W'(80);
			max_radius_q     <= RAD_W'(480);
			frame_width_q    <= COORD_W'(1280);
			frame_height_q   <= COORD_W'(720);
			vote_threshold_q <= VOTE_W'(7);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_RADIUS:     min_radius_q     <= cfg_data[RAD_W-1:0];
					REG_MAX_RADIUS:     max_radius_q     <= cfg_data[RAD_W-1:0];
					REG_FRAME_WIDTH:    frame_width_q    <= cfg_data[COORD_W-1:0];
					REG_FRAME_HEIGHT:   frame_height_q   <= cfg_data[COORD_W-1:0];
					REG_VOTE_THRESHOLD: vote_threshold_q <= cfg_data[VOTE_W-1:0];
					default: begin
					end
				endcase
			end

			if ((state_q == S_OUT) && (!out_valid_q || res_ready)) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (det_valid) begin
						det_q   <= det;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (det_q.action == ACT_CLEAR) begin
						used_q  <= '0;
						res_q   <= {ST_CLEARED, 4'd0, {VOTE_W{1'b0}}, 1'b0, 5'd0};
						state_q <= S_OUT;
					end else if (!pass) begin
						res_q   <= {ST_REJECTED, 4'd0, {VOTE_W{1'b0}}, 1'b0, 5'(used_q)};
						state_q <= S_OUT;
					end else if (used_q == '0) begin
						state_q <= S_PLACE;
					end else begin
						ptr_q   <= used_m1[IDX_W-1:0];
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						res_q   <= {ST_VOTED, 4'(ptr_q), votes_inc,
						            (votes_inc > vote_threshold_q), 5'(used_q)};
						state_q <= S_OUT;
					end else if (ptr_q == '0) begin
						state_q <= S_PLACE;
					end else begin
						ptr_q <= ptr_m1;
					end
				end
				S_PLACE: begin
					if (full) begin
						res_q <= {ST_FULL, 4'd0, {VOTE_W{1'b0}}, 1'b0, 5'(used_q)};
					end else begin
						used_q <= used_q + 1'b1;
						res_q  <= {ST_ADDED, 4'(used_q), {VOTE_W{1'b0}}, 1'b0,
						           5'(used_q + 1'b1)};
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || res_ready) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/sv/tb_detection_vote_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_detection_vote_table_unit
// Self-checking bench for the detection vote table. A scoreboard keeps its
// own copy of the light table and the settings, predicts the result of each
// accepted request and checks the results in order. Stimulus is a directed
// run over the filter borders, the square edge and newest-first matching,
// then random phases under several settings, including a long single-light
// run that drives the vote count into saturation. Both channels idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_detection_vote_table_unit;
	import dvt_pkg::*;

	localparam logic ACT_DETECT = 1'b0;
	localparam int   FRAC_ONE   = 1 << RADIUS_FRAC_BITS;
	localparam int   IDLE_LIMIT = 3000;

	class vote_scoreboard;
		logic [9:0]  min_radius     = 10'd80;
		logic [9:0]  max_radius     = 10'd480;
		logic [10:0] frame_width    = 11'd1280;
		logic [10:0] frame_height   = 11'd720;
		logic [7:0]  vote_threshold = 8'd7;
		logic [10:0] light_col[MAX_LIGHTS];
		logic [10:0] light_row[MAX_LIGHTS];
		logic [9:0]  light_size[MAX_LIGHTS];
		logic [7:0]  light_votes[MAX_LIGHTS];
		int unsigned used_entries = 0;
		res_t        expected_results[$];
		int          mismatches = 0;

		function void write_reg(reg_index_t idx, logic [10:0] value);
			case (idx)
				REG_MIN_RADIUS:     min_radius = value[9:0];
				REG_MAX_RADIUS:     max_radius = value[9:0];
				REG_FRAME_WIDTH:    frame_width = value;
				REG_FRAME_HEIGHT:   frame_height = value;
				REG_VOTE_THRESHOLD: vote_threshold = value[7:0];
				default: ;
			endcase
		endfunction

		function bit in_square(int k, int px, int py);
			int ex, ey, s;
			ex = light_col[k];
			ex = ex * FRAC_ONE;
			ey = light_row[k];
			ey = ey * FRAC_ONE;
			s = light_size[k];
			return (ex - s < px) && (ex + s > px) && (ey - s < py) && (ey + s > py);
		endfunction

		function res_t predict_outcome(det_t d);
			res_t r;
			int px, py, rr, fw, fh, k;
			bit passed, found;
			r = '0;
			found = 1'b0;
			if (d.action == ACT_CLEAR) begin
				used_entries = 0;
				r.status = ST_CLEARED;
			end else begin
				px = d.center_x;
				px = px * FRAC_ONE;
				py = d.center_y;
				py = py * FRAC_ONE;
				rr = d.radius;
				fw = frame_width;
				fw = fw * FRAC_ONE;
				fh = frame_height;
				fh = fh * FRAC_ONE;
				passed = (d.radius > min_radius) && (d.radius < max_radius) &&
					(px > rr) && (px + rr < fw) && (py > rr) && (py + rr < fh);
				if (!passed) begin
					r.status = ST_REJECTED;
				end else begin
					for (k = int'(used_entries) - 1; k >= 0; k--) begin
						if (in_square(k, px, py)) begin
							found = 1'b1;
							break;
						end
					end
					if (found) begin
						if (light_votes[k] != 8'hFF)
							light_votes[k]++;
						r.status = ST_VOTED;
						r.entry_index = 4'(k);
						r.entry_votes = light_votes[k];
						r.confirmed = light_votes[k] > vote_threshold;
					end else if (used_entries < MAX_LIGHTS) begin
						k = used_entries;
						light_col[k] = d.center_x;
						light_row[k] = d.center_y;
						light_size[k] = d.radius;
						light_votes[k] = '0;
						used_entries++;
						r.status = ST_ADDED;
						r.entry_index = 4'(k);
						r.confirmed = 8'd0 > vote_threshold;
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			r.entry_total = 5'(used_entries);
			return r;
		endfunction

		function void note_request(det_t d);
			expected_results = {expected_results, predict_outcome(d)};
		endfunction

		function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
			if (act_v !== exp_v) begin
				mismatches++;
				$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				return;
			end
			want = expected_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("entry_index", want.entry_index, got.entry_index);
			compare_field("entry_votes", want.entry_votes, got.entry_votes);
			compare_field("confirmed", want.confirmed, got.confirmed);
			compare_field("entry_total", want.entry_total, got.entry_total);
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        det_valid = 1'b0;
	logic        det_ready;
	det_t        det       = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_t        res;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [10:0] cfg_data  = '0;

	vote_scoreboard sb = new;
	int results_seen = 0;

	detection_vote_table_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.det_valid (det_valid),
		.det_ready (det_ready),
		.det       (det),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			sb.check_result(res);
			results_seen++;
		end
	end

	// receiver: changing stall modes, one long hold-off to back up the input
	initial begin
		int mode;
		int mode_left;
		bit held_off;
		mode = 0;
		mode_left = 0;
		held_off = 1'b0;
		forever begin
			@(posedge clk);
			if (!held_off && results_seen >= 60) begin
				held_off = 1'b1;
				res_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(3, 0);
					mode_left = $urandom_range(80, 20);
				end
				mode_left--;
				case (mode)
					0: res_ready <= 1'b1;
					1: res_ready <= 1'($urandom_range(1, 0));
					2: res_ready <= ($urandom_range(3, 0) == 0);
					default: res_ready <= ~res_ready;
				endcase
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((det_valid && det_ready) || (res_valid && res_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("tb_detection_vote_table_unit NOT OK");
				$finish;
			end
		end
	end

	function automatic logic [9:0] window_radius();
		int lo, hi;
		lo = sb.min_radius;
		lo = lo + 1;
		hi = sb.max_radius;
		hi = hi - 1;
		if (hi >= lo)
			return 10'($urandom_range(hi, lo));
		return 10'($urandom_range(1023, 0));
	endfunction

	function automatic logic [10:0] place_coord(logic [9:0] r, logic [10:0] extent);
		int lo, hi, rr, e;
		rr = r;
		e = extent;
		lo = rr / FRAC_ONE + 1;
		hi = (e * FRAC_ONE - rr - 1) / FRAC_ONE;
		if (hi < lo)
			return 11'($urandom_range(2047, 0));
		return 11'($urandom_range(hi, lo));
	endfunction

	function automatic logic [10:0] jitter(logic [10:0] base, logic [9:0] s);
		int maxd, v;
		maxd = (s == 0) ? 0 : (int'(s) - 1) / FRAC_ONE;
		v = int'(base) + int'($urandom_range(2 * maxd, 0)) - maxd;
		if (v < 0)
			v = 0;
		if (v > 2047)
			v = 2047;
		return 11'(v);
	endfunction

	function automatic det_t next_detection(bit focus);
		det_t d;
		int pick, k;
		d.action = ACT_DETECT;
		pick = $urandom_range(99, 0);
		if (focus)
			pick = (sb.used_entries > 0) ? 50 : 99;
		if (pick < 1 || pick < 14) begin
			d.center_x = 11'($urandom_range(2047, 0));
			d.center_y = 11'($urandom_range(2047, 0));
			d.radius = 10'($urandom_range(1023, 0));
			if (pick < 1)
				d.action = ACT_CLEAR;
		end else if (pick < 60 && sb.used_entries > 0) begin
			if (focus)
				k = 0;
			else if ($urandom_range(1, 0) == 1)
				k = sb.used_entries - 1;
			else
				k = $urandom_range(sb.used_entries - 1, 0);
			d.center_x = jitter(sb.light_col[k], sb.light_size[k]);
			d.center_y = jitter(sb.light_row[k], sb.light_size[k]);
			d.radius = ($urandom_range(9, 0) < 7) ? sb.light_size[k] : window_radius();
		end else begin
			d.radius = window_radius();
			d.center_x = place_coord(d.radius, sb.frame_width);
			d.center_y = place_coord(d.radius, sb.frame_height);
		end
		return d;
	endfunction

	task automatic send_request(det_t d);
		det <= d;
		det_valid <= 1'b1;
		do @(posedge clk); while (!det_ready);
		sb.note_request(d);
	endtask

	task automatic send_fields(logic act, int x, int y, int r);
		det_t d;
		d.action = act;
		d.center_x = 11'(x);
		d.center_y = 11'(y);
		d.radius = 10'(r);
		send_request(d);
	endtask

	task automatic drain_results();
		det_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[10:0];
		sb.write_reg(idx, value[10:0]);
		@(posedge clk);
	endtask

	task automatic apply_config(int min_r, int max_r, int w, int h, int th);
		write_reg(REG_MIN_RADIUS, min_r);
		write_reg(REG_MAX_RADIUS, max_r);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_VOTE_THRESHOLD, th);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(int count, bit focus);
		int n, burst, gap;
		burst = $urandom_range(8, 1);
		for (n = 0; n < count; n++) begin
			send_request(next_detection(focus));
			burst--;
			if (burst == 0 && n != count - 1) begin
				gap = $urandom_range(7, 0);
				if (gap > 0) begin
					det_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 15)
					: $urandom_range(8, 1);
			end
		end
		drain_results();
	endtask

	initial begin
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: filter borders, square edge, newest-first order
		send_fields(ACT_CLEAR, 2047, 2047, 1023);
		send_fields(ACT_DETECT, 0, 0, 0);
		send_fields(ACT_DETECT, 2047, 2047, 1023);
		send_fields(ACT_DETECT, 100, 100, 80);
		send_fields(ACT_DETECT, 100, 100, 480);
		send_fields(ACT_DETECT, 100, 100, 81);
		send_fields(ACT_DETECT, 104, 96, 479);
		send_fields(ACT_DETECT, 6, 300, 96);
		send_fields(ACT_DETECT, 7, 300, 96);
		send_fields(ACT_DETECT, 1274, 300, 96);
		send_fields(ACT_DETECT, 1273, 300, 96);
		send_fields(ACT_DETECT, 600, 714, 96);
		send_fields(ACT_DETECT, 600, 713, 96);
		send_fields(ACT_DETECT, 600, 6, 96);
		send_fields(ACT_DETECT, 400, 400, 96);
		send_fields(ACT_DETECT, 406, 400, 96);
		send_fields(ACT_DETECT, 403, 400, 96);
		send_fields(ACT_DETECT, 397, 400, 96);
		// push the first light past the confirm mark
		for (n = 0; n < 7; n++)
			send_fields(ACT_DETECT, 100, 100, 200);
		send_fields(ACT_CLEAR, 0, 0, 0);
		drain_results();

		apply_config(64, 600, 1920, 1080, 5);
		run_random(100, 1'b0);

		apply_config(0, 1023, 2047, 2047, 0);
		run_random(80, 1'b0);

		// one light soaks up every vote until its count saturates
		apply_config(0, 1023, 1024, 1024, 254);
		send_fields(ACT_CLEAR, 1023, 0, 511);
		run_random(280, 1'b1);

		// empty radius window and a one-pixel frame
		apply_config(1023, 0, 1, 1, 255);
		run_random(40, 1'b0);

		apply_config(16, 200, 40, 2047, 3);
		run_random(60, 1'b0);

		repeat (20) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0t: %0d expected results never arrived", $time, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb_detection_vote_table_unit OK");
		end else begin
			$display("tb_detection_vote_table_unit NOT OK");
		end
		$finish;
	end

endmodule
